### sv/tpid_pkg.sv
// shared types, constants and helpers for the trajectory pid position controller
`default_nettype none

package tpid_pkg;

   localparam int CMD_W      = 3;
   localparam int COUNT_W    = 16;
   localparam int IDX_W      = 11;
   localparam int ANGLE_W    = 32;
   localparam int GAIN_W     = 25;
   localparam int LIMIT_W    = 31;
   localparam int LEN_W      = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 31;

   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 25;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = 60;

   // pos = round(|count| * 2949120 / 167), split as whole part plus a small remainder
   localparam int POS_MULT  = 67;
   localparam int POS_BIAS  = 83;
   localparam int POS_RECIP = 6429592;
   localparam int POS_SHIFT = 30;
   localparam int POS_WHOLE = 17659;
   localparam int POS_X_W   = 22;
   localparam int POS_MAG_W = 30;

   localparam int RND_BIAS  = 128;
   localparam int RND_SHIFT = 8;

   localparam logic [GAIN_W-1:0]  KP_RESET   = GAIN_W'(25600);
   localparam logic [GAIN_W-1:0]  KI_RESET   = GAIN_W'(0);
   localparam logic [GAIN_W-1:0]  KD_RESET   = GAIN_W'(256000);
   localparam logic [LIMIT_W-1:0] ILIM_RESET = LIMIT_W'(65536000);
   localparam logic [LEN_W-1:0]   LEN_RESET  = LEN_W'(1);

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK  = 3'd0,
      CMD_LOAD  = 3'd1,
      CMD_START = 3'd2,
      CMD_HOLD  = 3'd3,
      CMD_IDLE  = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_IDLE  = 2'd0,
      MODE_TRACK = 2'd1,
      MODE_HOLD  = 2'd2
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KP   = 3'd0,
      CSR_KI   = 3'd1,
      CSR_KD   = 3'd2,
      CSR_ILIM = 3'd3,
      CSR_LEN  = 3'd4
   } csr_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POS1,
      ST_POS1W,
      ST_POS2,
      ST_POS2W,
      ST_POS3,
      ST_POS3W,
      ST_POS4,
      ST_ERR,
      ST_SUM,
      ST_CLAMP,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_MUL_W,
      ST_FIN
   } state_type;

   typedef struct packed {
      logic                       valid;
      logic                       load;
      logic signed [MUL_A_W-1:0]  a;
      logic signed [MUL_B_W-1:0]  b;
      logic signed [ACC_W-1:0]    addend;
   } mac_op_type;

   function automatic logic signed [ANGLE_W-1:0] sat_33(input logic signed [ANGLE_W:0] x);
      logic signed [ANGLE_W-1:0] r;
      if (x[ANGLE_W] != x[ANGLE_W-1]) begin
         r = x[ANGLE_W] ? {1'b1, {(ANGLE_W-1){1'b0}}} : {1'b0, {(ANGLE_W-1){1'b1}}};
      end else begin
         r = x[ANGLE_W-1:0];
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### sv/tpid_if.sv
// request and response channel interfaces
`default_nettype none

interface tpid_req_if import tpid_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          command;
   logic signed [COUNT_W-1:0] encoder_count;
   logic [IDX_W-1:0]          point_index;
   logic signed [ANGLE_W-1:0] angle_value;

   modport source (output valid, command, encoder_count, point_index, angle_value,
                   input ready);
   modport sink   (input valid, command, encoder_count, point_index, angle_value,
                   output ready);
endinterface

interface tpid_rsp_if import tpid_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic                      drive_valid;
   logic signed [ANGLE_W-1:0] torque_command;
   logic signed [ANGLE_W-1:0] measured_angle;
   logic                      track_done;

   modport source (output valid, drive_valid, torque_command, measured_angle, track_done,
                   input ready);
   modport sink   (input valid, drive_valid, torque_command, measured_angle, track_done,
                   output ready);
endinterface

`default_nettype wire

### sv/tpid_ram.sv
// generic single write port ram with registered read
`default_nettype none

module tpid_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### sv/tpid_mac.sv
// shared two stage multiply accumulate unit
`default_nettype none

module tpid_mac import tpid_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  mac_op_type              op,
   output logic signed [ACC_W-1:0] acc
);

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [PROD_W-1:0]  prod_ff;
   logic                      valid_ff;
   logic                      load_ff;
   logic signed [ACC_W-1:0]   addend_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ACC_W-1:0]   acc_in;

   assign mul_a = op.a;
   assign mul_b = op.b;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= op.valid;
      end
   end

   always_comb begin
      acc_in = (load_ff ? addend_ff : acc_ff)
             + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   end

   always_ff @(posedge clock) begin
      prod_ff   <= mul_a * mul_b;
      load_ff   <= op.load;
      addend_ff <= op.addend;
      if (valid_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign acc = acc_ff;

endmodule

`default_nettype wire

### sv/trajectory_tracking_pid_position.sv
// top level of the trajectory tracking pid position controller
// Each request transaction returns exactly one response transaction. A tick in track or
// hold mode loads the response register after the position, error, sum, clamp and pid
// product states, and the next request is taken only after that load; every other
// command goes from the position passes straight to the final state. All of it runs
// on one shared 33x25 multiply-accumulate unit: three dependent passes turn the encoder
// count into degrees, then the proportional, integral and derivative products stream
// through it back to back.
// The response sits in an output register, so the next request is taken while the last
// response still waits. Trajectory points live in a ram of TRAJECTORY_DEPTH entries with
// no clearing after reset; a point must be loaded before it is tracked.
`default_nettype none

module trajectory_tracking_pid_position import tpid_pkg::*; #(
   parameter int TRAJECTORY_DEPTH = 2048
) (
   input  logic                  clock,
   input  logic                  reset,
   tpid_req_if.sink              req_chan,
   tpid_rsp_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int AW = $clog2(TRAJECTORY_DEPTH);
   localparam int LW = $clog2(TRAJECTORY_DEPTH + 1);

   // configuration
   logic signed [GAIN_W-1:0] kp_ff;
   logic signed [GAIN_W-1:0] ki_ff;
   logic signed [GAIN_W-1:0] kd_ff;
   logic [LIMIT_W-1:0]       ilim_ff;
   logic [LEN_W-1:0]         len_ff;

   // control state
   state_type                 state_ff;
   state_type                 state_in;
   mode_type                  mode_ff;
   logic [AW-1:0]             track_idx_ff;
   logic signed [ANGLE_W-1:0] integral_ff;
   logic signed [ANGLE_W-1:0] prev_err_ff;
   logic signed [ANGLE_W-1:0] hold_angle_ff;
   logic                      rsp_valid_ff;

   // per transaction payload
   logic [CMD_W-1:0]          cmd_ff;
   logic [COUNT_W:0]          cnt_mag_ff;
   logic                      cnt_neg_ff;
   logic signed [ANGLE_W-1:0] angle_ff;
   logic signed [ANGLE_W-1:0] pos_ff;
   logic signed [ANGLE_W-1:0] err_ff;
   logic signed [ANGLE_W-1:0] isum_ff;
   logic signed [ANGLE_W-1:0] iclamp_ff;
   logic signed [ANGLE_W:0]   deriv_ff;

   // response payload
   logic                      drive_valid_ff;
   logic signed [ANGLE_W-1:0] torque_ff;
   logic signed [ANGLE_W-1:0] meas_ff;
   logic                      done_ff;

   logic                      req_accept;
   logic                      out_free;
   logic                      commit;
   logic                      tick_act;
   logic                      is_track;
   logic [LW-1:0]             eff_len;
   logic [AW-1:0]             idx_fix;
   logic [AW:0]               idx_next;
   logic                      at_end;
   logic                      ram_we;
   logic signed [ANGLE_W-1:0] ram_rd;
   logic signed [ANGLE_W-1:0] target;
   logic signed [ANGLE_W-1:0] lim_pos;
   logic signed [ANGLE_W-1:0] lim_neg;
   logic signed [ANGLE_W-1:0] pos_mag;
   logic [COUNT_W:0]          cnt_abs;
   logic signed [ACC_W-1:0]   acc;
   logic signed [ACC_W-1:0]   acc_sh;
   logic signed [ANGLE_W-1:0] torque_sat;
   mac_op_type                mac_op;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept     = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign commit         = (state_ff == ST_FIN) && out_free;
   assign is_track       = (mode_ff == MODE_TRACK);
   assign tick_act       = (cmd_ff == CMD_TICK)
                         && (mode_ff == MODE_TRACK || mode_ff == MODE_HOLD);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff   <= KP_RESET;
         ki_ff   <= KI_RESET;
         kd_ff   <= KD_RESET;
         ilim_ff <= ILIM_RESET;
         len_ff  <= LEN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KP:   kp_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_KI:   ki_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_KD:   kd_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_ILIM: ilim_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_LEN:  len_ff  <= csr_wdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // trajectory length and index bookkeeping
   always_comb begin
      if (len_ff == '0) begin
         eff_len = LW'(1);
      end else if (32'(len_ff) > TRAJECTORY_DEPTH) begin
         eff_len = LW'(TRAJECTORY_DEPTH);
      end else begin
         eff_len = LW'(len_ff);
      end
      idx_fix  = (32'(track_idx_ff) >= 32'(eff_len)) ? '0 : track_idx_ff;
      idx_next = {1'b0, idx_fix} + (AW+1)'(1);
      at_end   = (32'(idx_next) >= 32'(eff_len));
   end

   // trajectory store
   assign ram_we = req_accept && (req_chan.command == CMD_LOAD)
                && (32'(req_chan.point_index) < TRAJECTORY_DEPTH);

   tpid_ram #(
      .WIDTH (ANGLE_W),
      .DEPTH (TRAJECTORY_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (AW'(req_chan.point_index)),
      .wr_data (req_chan.angle_value),
      .rd_addr (idx_fix),
      .rd_data (ram_rd)
   );

   tpid_mac u_mac (
      .clock (clock),
      .reset (reset),
      .op    (mac_op),
      .acc   (acc)
   );

   // datapath helpers
   always_comb begin
      cnt_abs = req_chan.encoder_count[COUNT_W-1]
              ? -{req_chan.encoder_count[COUNT_W-1], req_chan.encoder_count}
              :  {req_chan.encoder_count[COUNT_W-1], req_chan.encoder_count};
      pos_mag = {{(ANGLE_W-POS_MAG_W){1'b0}}, acc[POS_MAG_W-1:0]};
      target  = is_track ? ram_rd : hold_angle_ff;
      lim_pos = {1'b0, ilim_ff};
      lim_neg = -lim_pos;
      acc_sh  = acc >>> RND_SHIFT;
      if (&acc_sh[ACC_W-1:ANGLE_W-1] || ~|acc_sh[ACC_W-1:ANGLE_W-1]) begin
         torque_sat = acc_sh[ANGLE_W-1:0];
      end else if (acc_sh[ACC_W-1]) begin
         torque_sat = {1'b1, {(ANGLE_W-1){1'b0}}};
      end else begin
         torque_sat = {1'b0, {(ANGLE_W-1){1'b1}}};
      end
   end

   // sequencer: next state and mac issue
   always_comb begin
      state_in = state_ff;
      mac_op   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_POS1;
            end
         end
         ST_POS1: begin
            mac_op.valid  = 1'b1;
            mac_op.load   = 1'b1;
            mac_op.a      = {{(MUL_A_W-COUNT_W-1){1'b0}}, cnt_mag_ff};
            mac_op.b      = MUL_B_W'(POS_MULT);
            mac_op.addend = ACC_W'(POS_BIAS);
            state_in      = ST_POS1W;
         end
         ST_POS1W: state_in = ST_POS2;
         ST_POS2: begin
            mac_op.valid  = 1'b1;
            mac_op.load   = 1'b1;
            mac_op.a      = {{(MUL_A_W-POS_X_W){1'b0}}, acc[POS_X_W-1:0]};
            mac_op.b      = MUL_B_W'(POS_RECIP);
            mac_op.addend = '0;
            state_in      = ST_POS2W;
         end
         ST_POS2W: state_in = ST_POS3;
         ST_POS3: begin
            mac_op.valid  = 1'b1;
            mac_op.load   = 1'b1;
            mac_op.a      = {{(MUL_A_W-COUNT_W-1){1'b0}}, cnt_mag_ff};
            mac_op.b      = MUL_B_W'(POS_WHOLE);
            mac_op.addend = acc >>> POS_SHIFT;
            state_in      = ST_POS3W;
         end
         ST_POS3W: state_in = ST_POS4;
         ST_POS4:  state_in = tick_act ? ST_ERR : ST_FIN;
         ST_ERR:   state_in = ST_SUM;
         ST_SUM:   state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_MUL_P;
         ST_MUL_P: begin
            mac_op.valid  = 1'b1;
            mac_op.load   = 1'b1;
            mac_op.a      = {err_ff[ANGLE_W-1], err_ff};
            mac_op.b      = kp_ff;
            mac_op.addend = ACC_W'(RND_BIAS);
            state_in      = ST_MUL_I;
         end
         ST_MUL_I: begin
            mac_op.valid = 1'b1;
            mac_op.a     = {iclamp_ff[ANGLE_W-1], iclamp_ff};
            mac_op.b     = ki_ff;
            state_in     = ST_MUL_D;
         end
         ST_MUL_D: begin
            mac_op.valid = 1'b1;
            mac_op.a     = deriv_ff;
            mac_op.b     = kd_ff;
            state_in     = ST_MUL_W;
         end
         ST_MUL_W: state_in = ST_FIN;
         ST_FIN: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control and controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= MODE_IDLE;
         track_idx_ff  <= '0;
         integral_ff   <= '0;
         prev_err_ff   <= '0;
         hold_angle_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (commit) begin
            if (tick_act) begin
               integral_ff <= iclamp_ff;
               prev_err_ff <= err_ff;
               if (is_track) begin
                  if (at_end) begin
                     track_idx_ff  <= '0;
                     integral_ff   <= '0;
                     prev_err_ff   <= '0;
                     hold_angle_ff <= pos_ff;
                     mode_ff       <= MODE_HOLD;
                  end else begin
                     track_idx_ff <= idx_next[AW-1:0];
                  end
               end
            end else begin
               unique case (cmd_ff)
                  CMD_START: begin
                     mode_ff      <= MODE_TRACK;
                     track_idx_ff <= '0;
                  end
                  CMD_HOLD: begin
                     hold_angle_ff <= angle_ff;
                     track_idx_ff  <= '0;
                     mode_ff       <= MODE_HOLD;
                  end
                  CMD_IDLE: mode_ff <= MODE_IDLE;
                  default: ;
               endcase
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         cmd_ff     <= req_chan.command;
         cnt_mag_ff <= cnt_abs;
         cnt_neg_ff <= req_chan.encoder_count[COUNT_W-1];
         angle_ff   <= req_chan.angle_value;
      end
      if (state_ff == ST_POS4) begin
         pos_ff <= cnt_neg_ff ? -pos_mag : pos_mag;
      end
      if (state_ff == ST_ERR) begin
         err_ff <= sat_33({target[ANGLE_W-1], target} - {pos_ff[ANGLE_W-1], pos_ff});
      end
      if (state_ff == ST_SUM) begin
         isum_ff  <= sat_33({integral_ff[ANGLE_W-1], integral_ff}
                          + {err_ff[ANGLE_W-1], err_ff});
         deriv_ff <= {err_ff[ANGLE_W-1], err_ff} - {prev_err_ff[ANGLE_W-1], prev_err_ff};
      end
      if (state_ff == ST_CLAMP) begin
         if (isum_ff > lim_pos) begin
            iclamp_ff <= lim_pos;
         end else if (isum_ff < lim_neg) begin
            iclamp_ff <= lim_neg;
         end else begin
            iclamp_ff <= isum_ff;
         end
      end
      if (commit) begin
         drive_valid_ff <= tick_act;
         torque_ff      <= tick_act ? torque_sat : '0;
         meas_ff        <= pos_ff;
         done_ff        <= tick_act && is_track && at_end;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.drive_valid    = drive_valid_ff;
   assign rsp_chan.torque_command = torque_ff;
   assign rsp_chan.measured_angle = meas_ff;
   assign rsp_chan.track_done     = done_ff;

endmodule

`default_nettype wire

### sv/tpid_chk.sv
// port level checker for the trajectory pid position controller and its bind
`default_nettype none

module tpid_chk import tpid_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_drive_valid,
   input logic signed [ANGLE_W-1:0] rsp_torque_command,
   input logic signed [ANGLE_W-1:0] rsp_measured_angle,
   input logic                      rsp_track_done
);

   // a response stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transaction");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({rsp_drive_valid, rsp_torque_command,
                                           rsp_measured_angle, rsp_track_done}))
      else $error("response payload changed while stalled");

   // the block is busy right after taking a request
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_done_drive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_track_done |-> rsp_drive_valid)
      else $error("track done without drive");

   a_zero_torque: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_drive_valid |-> rsp_torque_command == '0)
      else $error("torque nonzero without drive");

endmodule

bind trajectory_tracking_pid_position tpid_chk u_tpid_chk (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_drive_valid    (rsp_chan.drive_valid),
   .rsp_torque_command (rsp_chan.torque_command),
   .rsp_measured_angle (rsp_chan.measured_angle),
   .rsp_track_done     (rsp_chan.track_done)
);

`default_nettype wire

### dv/tb_top.sv
`timescale 1ns / 100ps
// self-checking testbench for the trajectory tracking pid position controller
module tb_top;
   import tpid_pkg::*;

   localparam int     DEPTH       = 2048;
   localparam int     PRELOAD_MAX = 160;
   localparam int     WATCH_MAX   = 4000;
   localparam int     REPORT_MAX  = 10;
   localparam int     ANGLE_NUM   = 23592960;
   localparam int     ANGLE_DEN   = 1336;
   localparam longint S32_MAX     = 64'sd2147483647;
   localparam longint S32_MIN     = -64'sd2147483648;

   typedef struct packed {
      logic [CMD_W-1:0]          command;
      logic signed [COUNT_W-1:0] encoder_count;
      logic [IDX_W-1:0]          point_index;
      logic signed [ANGLE_W-1:0] angle_value;
   } motion_cmd_type;

   typedef struct packed {
      logic                      drive_valid;
      logic signed [ANGLE_W-1:0] torque_command;
      logic signed [ANGLE_W-1:0] measured_angle;
      logic                      track_done;
   } drive_out_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   tpid_req_if req_bus ();
   tpid_rsp_if rsp_bus ();

   trajectory_tracking_pid_position #(.TRAJECTORY_DEPTH(DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // controller mirror
   longint                    kp_gain;
   longint                    ki_gain;
   longint                    kd_gain;
   longint                    integ_limit;
   int unsigned               len_setting;
   mode_type                  ctl_mode;
   int unsigned               step_index;
   longint                    err_integral;
   longint                    last_error;
   longint                    hold_target;
   logic signed [ANGLE_W-1:0] path_points [DEPTH];

   bit             points_loaded [DEPTH];
   motion_cmd_type pending_cmds [$];
   drive_out_type  expected_drive [$];
   int             stall_pct;
   int             mismatch_count;
   int             idle_cycles;
   int             cmds_issued;
   int             resp_seen;
   logic           req_taken;

   function automatic longint clip32(longint x);
      if (x > S32_MAX) return S32_MAX;
      if (x < S32_MIN) return S32_MIN;
      return x;
   endfunction

   function automatic longint count_to_angle(longint count);
      longint num;
      num = count * ANGLE_NUM;
      if (num >= 0) return (num + ANGLE_DEN / 2) / ANGLE_DEN;
      return -((-num + ANGLE_DEN / 2) / ANGLE_DEN);
   endfunction

   function automatic int unsigned span_of(int unsigned len);
      if (len < 1) return 1;
      if (len > DEPTH) return DEPTH;
      return len;
   endfunction

   function automatic drive_out_type predict_drive(motion_cmd_type m);
      drive_out_type r;
      longint        pos;
      longint        target;
      longint        err;
      longint        integ;
      longint        deriv;
      longint        acc;
      bit            tracking;
      r = '0;
      pos = count_to_angle(longint'($signed(m.encoder_count)));
      r.measured_angle = ANGLE_W'(pos);
      if (m.command == CMD_TICK && ctl_mode != MODE_IDLE) begin
         tracking = (ctl_mode == MODE_TRACK);
         if (tracking) begin
            if (step_index >= span_of(len_setting)) step_index = 0;
            target = longint'(path_points[IDX_W'(step_index)]);
         end else begin
            target = hold_target;
         end
         err = clip32(target - pos);
         integ = clip32(err_integral + err);
         if (integ > integ_limit) integ = integ_limit;
         if (integ < -integ_limit) integ = -integ_limit;
         err_integral = integ;
         deriv = err - last_error;
         last_error = err;
         acc = kp_gain * err + ki_gain * integ + kd_gain * deriv;
         r.torque_command = ANGLE_W'(clip32((acc + RND_BIAS) >>> RND_SHIFT));
         r.drive_valid = 1'b1;
         if (tracking) begin
            step_index++;
            if (step_index >= span_of(len_setting)) begin
               step_index   = 0;
               err_integral = 0;
               last_error   = 0;
               hold_target  = pos;
               ctl_mode     = MODE_HOLD;
               r.track_done = 1'b1;
            end
         end
      end else begin
         case (m.command)
            CMD_LOAD: path_points[m.point_index] = m.angle_value;
            CMD_START: begin
               ctl_mode   = MODE_TRACK;
               step_index = 0;
            end
            CMD_HOLD: begin
               hold_target = longint'($signed(m.angle_value));
               step_index  = 0;
               ctl_mode    = MODE_HOLD;
            end
            CMD_IDLE: ctl_mode = MODE_IDLE;
            default: ;
         endcase
      end
      return r;
   endfunction

   function automatic void queue_cmd(logic [CMD_W-1:0] c, logic [COUNT_W-1:0] count,
                                     logic [IDX_W-1:0] idx, logic [ANGLE_W-1:0] angle);
      motion_cmd_type m;
      m.command       = c;
      m.encoder_count = count;
      m.point_index   = idx;
      m.angle_value   = angle;
      if (c == CMD_LOAD) points_loaded[idx] = 1'b1;
      pending_cmds.push_back(m);
      cmds_issued++;
   endfunction

   function automatic logic [ANGLE_W-1:0] rand_angle();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 60) return ANGLE_W'(int'($urandom_range(1 << 25)) - (1 << 24));
      if (pick < 85) return ANGLE_W'(int'($urandom_range(1 << 30)) - (1 << 29));
      return $urandom;
   endfunction

   function automatic logic [COUNT_W-1:0] rand_count();
      if ($urandom_range(1) != 0) return COUNT_W'(int'($urandom_range(400)) - 200);
      return COUNT_W'($urandom);
   endfunction

   function automatic longint rand_gain();
      logic signed [GAIN_W-1:0] g;
      if ($urandom_range(99) < 60) return longint'(int'($urandom_range(8192)) - 4096);
      g = GAIN_W'($urandom);
      return longint'(g);
   endfunction

   function automatic longint rand_limit();
      if ($urandom_range(1) != 0) return longint'($urandom_range(1 << 24));
      return longint'($urandom_range(32'h7fff_ffff));
   endfunction

   function automatic void queue_random_cmd();
      int unsigned      pick;
      logic [IDX_W-1:0] idx;
      pick = $urandom_range(99);
      idx  = IDX_W'($urandom);
      if (pick < 55) begin
         queue_cmd(CMD_TICK, rand_count(), idx, $urandom);
      end else if (pick < 70) begin
         if ($urandom_range(9) < 7) idx = IDX_W'($urandom_range(31));
         queue_cmd(CMD_LOAD, rand_count(), idx, rand_angle());
      end else if (pick < 80) begin
         queue_cmd(CMD_START, rand_count(), idx, $urandom);
      end else if (pick < 88) begin
         queue_cmd(CMD_HOLD, rand_count(), idx, rand_angle());
      end else if (pick < 94) begin
         queue_cmd(CMD_IDLE, rand_count(), idx, $urandom);
      end else begin
         queue_cmd(CMD_W'(CMD_IDLE + $urandom_range(1, 3)), rand_count(), idx, $urandom);
      end
   endfunction

   task automatic write_csr(csr_type idx, longint value);
      logic [CSR_DATA_W-1:0] bits;
      bits = CSR_DATA_W'(value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= bits;
      @(posedge clock);
      @(negedge clock);
      case (idx)
         CSR_KP:   kp_gain     = longint'($signed(bits[GAIN_W-1:0]));
         CSR_KI:   ki_gain     = longint'($signed(bits[GAIN_W-1:0]));
         CSR_KD:   kd_gain     = longint'($signed(bits[GAIN_W-1:0]));
         CSR_ILIM: integ_limit = longint'(bits[LIMIT_W-1:0]);
         CSR_LEN:  len_setting = 32'(bits[LEN_W-1:0]);
         default: ;
      endcase
   endtask

   task automatic wait_drain();
      do @(negedge clock);
      while (resp_seen != cmds_issued);
   endtask

   task automatic run_phase(longint kp, longint ki, longint kd, longint lim,
                            longint len, int n_items, int pct);
      wait_drain();
      write_csr(CSR_KP, kp);
      write_csr(CSR_KI, ki);
      write_csr(CSR_KD, kd);
      write_csr(CSR_ILIM, lim);
      write_csr(CSR_LEN, len);
      csr_we <= 1'b0;
      stall_pct = pct;
      // every point the trajectory can reach must be loaded before a tick
      for (int i = 0; i < int'(span_of(int'(len))) && i < PRELOAD_MAX; i++) begin
         if (!points_loaded[i]) queue_cmd(CMD_LOAD, rand_count(), IDX_W'(i), rand_angle());
      end
      repeat (n_items) queue_random_cmd();
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(negedge clock) begin : drive_req
      motion_cmd_type m;
      if (reset) begin
         req_bus.valid <= 1'b0;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
         if (!req_bus.valid || req_taken) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= stall_pct) begin
               m = pending_cmds.pop_front();
               req_bus.valid         <= 1'b1;
               req_bus.command       <= m.command;
               req_bus.encoder_count <= m.encoder_count;
               req_bus.point_index   <= m.point_index;
               req_bus.angle_value   <= m.angle_value;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watch_bus
      motion_cmd_type m;
      drive_out_type  got;
      drive_out_type  want;
      bit             moved;
      moved = 1'b0;
      req_taken <= req_bus.valid && req_bus.ready;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            m.command       = req_bus.command;
            m.encoder_count = req_bus.encoder_count;
            m.point_index   = req_bus.point_index;
            m.angle_value   = req_bus.angle_value;
            expected_drive.push_back(predict_drive(m));
            moved = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            moved = 1'b1;
            got.drive_valid    = rsp_bus.drive_valid;
            got.torque_command = rsp_bus.torque_command;
            got.measured_angle = rsp_bus.measured_angle;
            got.track_done     = rsp_bus.track_done;
            if (expected_drive.size() == 0) begin
               if (mismatch_count < REPORT_MAX)
                  $display("%0t: response transaction with none expected", $realtime);
               mismatch_count++;
            end else begin
               want = expected_drive.pop_front();
               resp_seen++;
               if (got.drive_valid !== want.drive_valid
                   || got.torque_command !== want.torque_command
                   || got.measured_angle !== want.measured_angle
                   || got.track_done !== want.track_done) begin
                  if (mismatch_count < REPORT_MAX) begin
                     $display("%0t: mismatch expected valid=%0b torque=%0d angle=%0d done=%0b",
                              $realtime, want.drive_valid, want.torque_command,
                              want.measured_angle, want.track_done);
                     $display("%0t:          actual valid=%0b torque=%0d angle=%0d done=%0b",
                              $realtime, got.drive_valid, got.torque_command,
                              got.measured_angle, got.track_done);
                  end
                  mismatch_count++;
               end
            end
         end
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCH_MAX) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      reset                 = 1'b1;
      csr_we                = 1'b0;
      csr_index             = CSR_KP;
      csr_wdata             = '0;
      req_bus.valid         = 1'b0;
      req_bus.command       = CMD_TICK;
      req_bus.encoder_count = '0;
      req_bus.point_index   = '0;
      req_bus.angle_value   = '0;
      rsp_bus.ready         = 1'b0;
      req_taken             = 1'b0;
      stall_pct             = 15;
      mismatch_count        = 0;
      idle_cycles           = 0;
      cmds_issued           = 0;
      resp_seen             = 0;
      kp_gain               = longint'($signed(KP_RESET));
      ki_gain               = longint'($signed(KI_RESET));
      kd_gain               = longint'($signed(KD_RESET));
      integ_limit           = longint'(ILIM_RESET);
      len_setting           = 32'(LEN_RESET);
      ctl_mode              = MODE_IDLE;
      step_index            = 0;
      err_integral          = 0;
      last_error            = 0;
      hold_target           = 0;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed transactions at reset gains, length one
      queue_cmd(CMD_TICK, 16'h0000, 11'h000, 32'h0000_0000);
      queue_cmd(CMD_LOAD, 16'h0000, 11'h000, 32'd65536000);
      queue_cmd(CMD_LOAD, 16'h7fff, 11'h7ff, 32'h8000_0000);
      queue_cmd(CMD_LOAD, 16'h8000, 11'h400, 32'h7fff_ffff);
      queue_cmd(CMD_START, 16'h0000, 11'h000, 32'h0000_0000);
      queue_cmd(CMD_TICK, 16'h7fff, 11'h000, 32'h0000_0000);
      queue_cmd(CMD_TICK, 16'h8000, 11'h000, 32'h0000_0000);
      queue_cmd(CMD_TICK, 16'h0000, 11'h000, 32'h0000_0000);
      queue_cmd(CMD_HOLD, 16'h0000, 11'h000, 32'h7fff_ffff);
      queue_cmd(CMD_TICK, 16'h8000, 11'h000, 32'h0000_0000);
      queue_cmd(CMD_HOLD, 16'h0000, 11'h000, 32'h8000_0000);
      queue_cmd(CMD_TICK, 16'h7fff, 11'h000, 32'h0000_0000);
      queue_cmd(CMD_TICK, 16'h7fff, 11'h000, 32'h0000_0000);
      queue_cmd(CMD_IDLE, 16'h0000, 11'h000, 32'h0000_0000);
      queue_cmd(CMD_TICK, 16'h0001, 11'h000, 32'h0000_0000);
      for (int k = 1; k <= 3; k++)
         queue_cmd(CMD_W'(CMD_IDLE + k), 16'hffff, 11'h7ff, 32'hffff_ffff);
      queue_cmd(CMD_START, 16'h0000, 11'h000, 32'h0000_0000);
      queue_cmd(CMD_HOLD, 16'h0000, 11'h000, 32'h0000_0000);
      queue_cmd(CMD_TICK, 16'h0001, 11'h000, 32'h0000_0000);
      queue_cmd(CMD_TICK, 16'hffff, 11'h000, 32'h0000_0000);
      queue_cmd(CMD_START, 16'h0000, 11'h000, 32'h0000_0000);
      queue_cmd(CMD_TICK, 16'd1336, 11'h000, 32'h0000_0000);

      // gain and limit extremes, zero length
      run_phase(16777215, -16777216, 0, 32'h7fff_ffff, 0, 100, 15);

      // length above depth with no stalls, stays inside the preloaded points
      run_phase(-16777216, 16777215, -16777216, 0, 4095, 0, 0);
      queue_cmd(CMD_START, 16'h0000, 11'h000, 32'h0000_0000);
      repeat (40) queue_cmd(CMD_TICK, rand_count(), IDX_W'($urandom), $urandom);

      for (int p = 0; p < 6; p++)
         run_phase(rand_gain(), rand_gain(), rand_gain(), rand_limit(),
                   (p == 0) ? DEPTH : $urandom_range(1, 12), 90, 15);

      wait_drain();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && expected_drive.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
